// File: src/hjg_pkg.sv
// Halton jitter generator: shared types and constants.
// No dependencies; used by every module of the block except the checker.
package hjg_pkg;

    // Field and datapath widths
    localparam int IN_W  = 32;  // frame number word
    localparam int SC_W  = 16;  // sample count register
    localparam int JIT_W = 16;  // one jitter value
    localparam int IDX_W = 17;  // sequence index, 1 .. 65535
    localparam int DEN_W = 18;  // 3^k for up to eleven base-3 digits
    localparam int REM_W = 19;  // restoring remainder, one bit above divisor

    // Divide by three: q = (x * RECIP3) >> RECIP3_SHIFT, exact for x < 2^19
    localparam int              RECIP3_W     = 18;
    localparam int              RECIP3_SHIFT = 19;
    localparam logic [RECIP3_W-1:0] RECIP3   = 18'd174763;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_DIGIT,
        ST_DIV,
        ST_LOAD
    } t_state;

    // Operands of one restoring divide step
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] divisor;
        logic             shift_in;
    } t_div_op;

    // Result of one restoring divide step
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             qbit;
    } t_div_res;

endpackage

// File: src/hjg_div_step.sv
// One restoring divide step: shift a bit into the remainder, subtract if it fits.
// Depends on hjg_pkg for the operand and result structs.
module hjg_div_step (
    input  hjg_pkg::t_div_op  i_op,
    output hjg_pkg::t_div_res o_res
);

    logic [hjg_pkg::REM_W-1:0] w_shift;
    logic [hjg_pkg::REM_W-1:0] w_div;
    logic                      w_fits;

    // Shift in the next bit and compare against the divisor
    always_comb begin
        w_shift     = {i_op.rem[hjg_pkg::REM_W-2:0], i_op.shift_in};
        w_div       = hjg_pkg::REM_W'(i_op.divisor);
        w_fits      = (w_shift >= w_div);
        o_res.qbit  = w_fits;
        o_res.rem   = w_fits ? (w_shift - w_div) : w_shift;
    end

endmodule

// File: src/hjg_digit3.sv
// Splits the lowest base-3 digit off an index by reciprocal multiplication.
// Depends on hjg_pkg for widths and the reciprocal constant.
module hjg_digit3 (
    input  logic [hjg_pkg::IDX_W-1:0] i_x,
    output logic [hjg_pkg::IDX_W-1:0] o_q,
    output logic [1:0]                o_d
);

    localparam int PROD_W = hjg_pkg::IDX_W + hjg_pkg::RECIP3_W;

    logic [PROD_W-1:0]         w_prod;
    logic [hjg_pkg::IDX_W-1:0] w_rem;

    // Quotient by three, then the digit as what is left over
    always_comb begin
        w_prod = PROD_W'(i_x) * PROD_W'(hjg_pkg::RECIP3);
        o_q    = hjg_pkg::IDX_W'(w_prod >> hjg_pkg::RECIP3_SHIFT);
        w_rem  = i_x - ((o_q << 1) + o_q);
        o_d    = w_rem[1:0];
    end

endmodule

// File: src/hjg_center.sv
// Subtracts one half from a radical inverse and saturates to signed 16 bits.
// Depends on hjg_pkg for the jitter width.
module hjg_center #(
    parameter int FRACTION_BITS = 16
) (
    input  logic [FRACTION_BITS-1:0]       i_h,
    output logic signed [hjg_pkg::JIT_W-1:0] o_j
);

    localparam int CW = (FRACTION_BITS + 1 > hjg_pkg::JIT_W + 1) ?
                        FRACTION_BITS + 1 : hjg_pkg::JIT_W + 1;
    localparam logic signed [CW-1:0] SAT_HI = CW'((1 << (hjg_pkg::JIT_W - 1)) - 1);
    localparam logic signed [CW-1:0] SAT_LO = ~SAT_HI;
    localparam logic [CW-1:0]        HALF   = CW'(1) << (FRACTION_BITS - 1);

    logic signed [CW-1:0] w_v;

    // Center around zero, then clamp to the output range
    always_comb begin
        w_v = signed'(CW'(i_h) - HALF);
        priority if (w_v > SAT_HI) begin
            o_j = SAT_HI[hjg_pkg::JIT_W-1:0];
        end else if (w_v < SAT_LO) begin
            o_j = SAT_LO[hjg_pkg::JIT_W-1:0];
        end else begin
            o_j = w_v[hjg_pkg::JIT_W-1:0];
        end
    end

endmodule

// File: src/halton_jitter_generator_core.sv
// Halton jitter generator top level: sequencer, datapath registers and stream ports.
// Depends on hjg_pkg, hjg_div_step, hjg_digit3 and hjg_center.

// One word in, one word out. Each accepted frame number passes through the modulo,
// digit and division states, and its result is loaded into the output register. The
// sequencer then returns to idle and can accept the next word in the following cycle.
// FW is the frame width, FRAME_BITS capped at 32. k is the base-3 digit count of the
// index, from one to eleven. A single restoring divide-step unit does the arithmetic. It
// is used first for the frame modulo, one bit per cycle, and then for the base-3 radical
// inverse division, one quotient bit per cycle. In between, the digit state splits off
// the k base-3 digits one at a time. The base-2 value is a plain bit reversal.
// s_axis_tready is high only while the sequencer is idle. The output register holds a
// finished word, so the next frame can be accepted before that word is taken. A result
// whose output register is still full waits in the sequencer. A sample count of zero
// bypasses the arithmetic and goes straight to the load state, which loads zero jitter.
// Write sample_count only while no word is in flight.
module halton_jitter_generator_core #(
    parameter int FRACTION_BITS = 16,
    parameter int FRAME_BITS    = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [hjg_pkg::SC_W-1:0]  i_cfg_wdata,   // sample_count
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [31:0]               s_axis_tdata,  // [31:0] frame_index
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [63:0]               m_axis_tdata   // [15:0] jitter_x, [31:16] jitter_y,
                                                     // [47:32] prior_jitter_x,
                                                     // [63:48] prior_jitter_y
);

    localparam int FW    = (FRAME_BITS < hjg_pkg::IN_W) ? FRAME_BITS : hjg_pkg::IN_W;
    localparam int F     = FRACTION_BITS;
    localparam int MAXN  = (FW > F) ? FW : F;
    localparam int CNT_W = $clog2(MAXN);
    localparam int XW    = (F > hjg_pkg::IDX_W) ? F : hjg_pkg::IDX_W;
    localparam int JW    = hjg_pkg::JIT_W;

    hjg_pkg::t_state r_state;
    hjg_pkg::t_state n_state;

    // Sequencer and datapath registers
    logic [hjg_pkg::SC_W-1:0]  r_sc;
    logic [FW-1:0]             r_frame;
    logic [hjg_pkg::REM_W-1:0] r_rem;
    logic [CNT_W-1:0]          r_cnt;
    logic [hjg_pkg::IDX_W-1:0] r_idx3;
    logic [hjg_pkg::DEN_W-1:0] r_rev3;
    logic [hjg_pkg::DEN_W-1:0] r_den3;
    logic [F-1:0]              r_hx;
    logic [F-1:0]              r_q;
    logic                      r_m_valid;
    logic [63:0]               r_m_data;
    logic [JW-1:0]             r_last_x;
    logic [JW-1:0]             r_last_y;

    // Combinational control and datapath
    logic                      w_accept;
    logic                      w_mod_last;
    logic                      w_div_last;
    logic                      w_load;
    hjg_pkg::t_div_op          w_op;
    hjg_pkg::t_div_res         w_res;
    logic [hjg_pkg::IDX_W-1:0] w_idx;
    logic [XW-1:0]             w_idx_ext;
    logic [F-1:0]              w_hx;
    logic [hjg_pkg::IDX_W-1:0] w_q3;
    logic [1:0]                w_d3;
    logic signed [JW-1:0]      w_cx;
    logic signed [JW-1:0]      w_cy;
    logic [JW-1:0]             w_jx;
    logic [JW-1:0]             w_jy;

    hjg_div_step u_div (
        .i_op  (w_op),
        .o_res (w_res)
    );

    hjg_digit3 u_dig (
        .i_x (r_idx3),
        .o_q (w_q3),
        .o_d (w_d3)
    );

    hjg_center #(.FRACTION_BITS(F)) u_cx (
        .i_h (r_hx),
        .o_j (w_cx)
    );

    hjg_center #(.FRACTION_BITS(F)) u_cy (
        .i_h (r_q),
        .o_j (w_cy)
    );

    // Sequencer outputs: handshakes, step markers and divide operand select
    always_comb begin
        s_axis_tready = (r_state == hjg_pkg::ST_IDLE);
        w_accept      = s_axis_tvalid && s_axis_tready;
        w_mod_last    = (r_cnt == CNT_W'(FW - 1));
        w_div_last    = (r_cnt == CNT_W'(F - 1));
        w_load        = (r_state == hjg_pkg::ST_LOAD) && (!r_m_valid || m_axis_tready);
        w_op.rem      = r_rem;
        if (r_state == hjg_pkg::ST_MOD) begin
            w_op.divisor  = hjg_pkg::DEN_W'(r_sc);
            w_op.shift_in = r_frame[FW-1];
        end else begin
            w_op.divisor  = r_den3;
            w_op.shift_in = 1'b0;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hjg_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = (r_sc == '0) ? hjg_pkg::ST_LOAD : hjg_pkg::ST_MOD;
                end
            end
            hjg_pkg::ST_MOD: begin
                if (w_mod_last) begin
                    n_state = hjg_pkg::ST_DIGIT;
                end
            end
            hjg_pkg::ST_DIGIT: begin
                if (r_idx3 == '0) begin
                    n_state = hjg_pkg::ST_DIV;
                end
            end
            hjg_pkg::ST_DIV: begin
                if (w_div_last) begin
                    n_state = hjg_pkg::ST_LOAD;
                end
            end
            hjg_pkg::ST_LOAD: begin
                if (w_load) begin
                    n_state = hjg_pkg::ST_IDLE;
                end
            end
            default: n_state = hjg_pkg::ST_IDLE;
        endcase
    end

    // Form the index from the final remainder and bit-reverse it for base 2
    always_comb begin
        w_idx     = hjg_pkg::IDX_W'(w_res.rem[hjg_pkg::SC_W-1:0]) + hjg_pkg::IDX_W'(1);
        w_idx_ext = XW'(w_idx);
        for (int i = 0; i < F; i++) begin
            w_hx[F-1-i] = w_idx_ext[i];
        end
    end

    // Zero jitter when the sequence is disabled
    always_comb begin
        w_jx = (r_sc == '0) ? '0 : w_cx;
        w_jy = (r_sc == '0) ? '0 : w_cy;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hjg_pkg::ST_IDLE;
            r_sc      <= '0;
            r_m_valid <= 1'b0;
            r_last_x  <= '0;
            r_last_y  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_sc <= i_cfg_wdata;
            end
            if (w_load) begin
                r_m_valid <= 1'b1;
                r_last_x  <= w_jx;
                r_last_y  <= w_jy;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath: modulo, digit split, division, output word
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            hjg_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_frame <= s_axis_tdata[FW-1:0];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                end
            end
            hjg_pkg::ST_MOD: begin
                r_rem   <= w_res.rem;
                r_frame <= r_frame << 1;
                r_cnt   <= r_cnt + CNT_W'(1);
                if (w_mod_last) begin
                    r_idx3 <= w_idx;
                    r_hx   <= w_hx;
                    r_rev3 <= '0;
                    r_den3 <= hjg_pkg::DEN_W'(1);
                end
            end
            hjg_pkg::ST_DIGIT: begin
                if (r_idx3 != '0) begin
                    r_idx3 <= w_q3;
                    r_rev3 <= (r_rev3 << 1) + r_rev3 + hjg_pkg::DEN_W'(w_d3);
                    r_den3 <= (r_den3 << 1) + r_den3;
                end else begin
                    r_rem <= hjg_pkg::REM_W'(r_rev3);
                    r_cnt <= '0;
                end
            end
            hjg_pkg::ST_DIV: begin
                r_rem <= w_res.rem;
                r_q   <= {r_q[F-2:0], w_res.qbit};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            hjg_pkg::ST_LOAD: begin
                if (w_load) begin
                    r_m_data <= {r_last_y, r_last_x, w_jy, w_jx};
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// File: src/hjg_checker.sv
// Port-level checks for the Halton jitter generator, bound to the top level.
// Depends only on the top level's ports.
module hjg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [15:0] i_cfg_wdata,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    logic [15:0] r_sc;
    logic [31:0] r_last;

    // Track the sample count and the last delivered jitter pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc   <= '0;
            r_last <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sc <= i_cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                r_last <= m_axis_tdata[31:0];
            end
        end
    end

    // Drop ready for the cycle after a word is taken in
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a word was in flight");

    // Prior pair equals the pair delivered before
    a_prior_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[63:32] == r_last))
        else $error("prior jitter pair does not match last delivered pair");

    // Disabled sequence gives zero jitter
    a_zero_when_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_sc == 16'd0)) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("nonzero jitter with sample count zero");

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output word changed");

    // Empty output after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind halton_jitter_generator_core hjg_checker u_hjg_checker (.*);
